FILE: sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Depends on nothing; every other file of the block imports it.
package spq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int DATA_W        = 32;
    localparam int OCC_W         = 4;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_RSVD      = 2'd3
    } status_t;

    localparam logic signed [DATA_W-1:0] HEAD_EMPTY = -32'sd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming request
        logic exec;   // apply the request and fill the output register
    } ctl_cmd_t;

endpackage

FILE: sv/spq_ctrl.sv
// Controller of the sorted priority queue: request handshake and output valid.
// Depends on spq_pkg.
module spq_ctrl import spq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign slot_free = !out_valid_reg || m_tready;
    assign cmd.load  = s_tvalid && (state_reg == S_IDLE);
    assign cmd.exec  = (state_reg == S_EXEC) && slot_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_EXEC;
            end
            S_EXEC: begin
                if (slot_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.exec) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/spq_datapath.sv
// Datapath of the sorted priority queue: request register, the sorted row of
// entry cells with their parallel compare, the entry count and the result register.
// Depends on spq_pkg.
module spq_datapath import spq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ctl_cmd_t                 cmd,
    input  op_t                      in_op,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic signed [DATA_W-1:0] in_priority,
    output logic signed [DATA_W-1:0] out_head,
    output status_t                  out_status,
    output logic [OCC_W-1:0]         out_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    // Request register.
    op_t                      op_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] prio_reg;

    // Entry cells, slot 0 is the head.
    logic signed [DATA_W-1:0] ent_val_reg [DEPTH];
    logic signed [DATA_W-1:0] ent_pri_reg [DEPTH];
    logic [CW-1:0]            count_reg, count_next;

    logic [DEPTH-1:0] gt;
    logic             is_full, is_empty, do_enq, do_deq;

    // Result register.
    logic signed [DATA_W-1:0] head_reg, head_next;
    status_t                  status_reg, status_next;
    logic [OCC_W-1:0]         occ_reg;
    logic [CW+OCC_W-1:0]      count_ext;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign do_enq   = cmd.exec && (op_reg == OP_ENQ) && !is_full;
    assign do_deq   = cmd.exec && (op_reg == OP_DEQ) && !is_empty;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_op;
            value_reg <= in_value;
            prio_reg  <= in_priority;
        end
    end

    // A stored entry moves down when its priority is strictly greater than
    // the new one; the mask is contiguous at the tail because the row is sorted.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            gt[i] = (CW'(i) < count_reg) && (ent_pri_reg[i] > prio_reg);
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic from_prev, take_new, from_next;
        if (i == 0) begin : g_first
            assign from_prev = 1'b0;
        end else begin : g_rest
            assign from_prev = gt[i-1];
        end
        assign take_new = !from_prev && (gt[i] || (CW'(i) == count_reg));
        if (i == DEPTH - 1) begin : g_last
            assign from_next = 1'b0;
        end else begin : g_mid
            assign from_next = 1'b1;
        end

        always_ff @(posedge aclk) begin
            if (do_enq) begin
                if (from_prev) begin
                    ent_val_reg[i] <= ent_val_reg[(i == 0) ? 0 : i-1];
                    ent_pri_reg[i] <= ent_pri_reg[(i == 0) ? 0 : i-1];
                end else if (take_new) begin
                    ent_val_reg[i] <= value_reg;
                    ent_pri_reg[i] <= prio_reg;
                end
            end else if (do_deq && from_next) begin
                ent_val_reg[i] <= ent_val_reg[(i == DEPTH - 1) ? i : i+1];
                ent_pri_reg[i] <= ent_pri_reg[(i == DEPTH - 1) ? i : i+1];
            end
        end
    end

    always_comb begin
        count_next  = count_reg;
        head_next   = '0;
        status_next = ST_OK;
        case (op_reg)
            OP_ENQ: begin
                if (is_full) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    count_next = count_reg + CW'(1);
                end
            end
            OP_DEQ, OP_PEEK: begin
                if (is_empty) begin
                    head_next   = HEAD_EMPTY;
                    status_next = ST_UNDERFLOW;
                end else begin
                    head_next = ent_val_reg[0];
                    if (op_reg == OP_DEQ) count_next = count_reg - CW'(1);
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    // Occupancy is the count reduced to four bits.
    assign count_ext = {{OCC_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            head_reg   <= head_next;
            status_reg <= status_next;
            occ_reg    <= count_ext[OCC_W-1:0];
        end
    end

    assign out_head      = head_reg;
    assign out_status    = status_reg;
    assign out_occupancy = occ_reg;

endmodule

FILE: sv/sorted_priority_queue.sv
// Sorted priority queue: a request beat is captured in the request register, and the cell
// row is updated when the request is applied, which also loads the result register and
// raises m_tvalid; the request is applied once the result register is free or draining.
// A new request is taken only after the previous one has been applied. A result waiting
// for m_tready lets one more request in, which then waits until that result is taken.
// Reset (aresetn low at a clock edge) empties the queue and drops any pending result.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // [31:0] item_value, [63:32] item_priority
    input  logic [1:0]  s_tuser,  // [1:0] op
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [31:0] head_value, [35:32] occupancy, zero above
    output logic [1:0]  m_tuser   // [1:0] status
);

    ctl_cmd_t                 cmd;
    logic signed [DATA_W-1:0] head;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;

    // The controller owns both handshakes; it captures a request in the idle
    // state and applies it once the output register is free or being drained.
    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath compares the new priority with every cell at once and
    // shifts the tail of the row down on enqueue, or the whole row up on dequeue.
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_op         (op_t'(s_tuser)),
        .in_value      (s_tdata[31:0]),
        .in_priority   (s_tdata[63:32]),
        .out_head      (head),
        .out_status    (status),
        .out_occupancy (occupancy)
    );

    assign m_tdata = {4'b0000, occupancy, head};
    assign m_tuser = status;

endmodule

FILE: sv/spq_checker.sv
// Port-level checker for the sorted priority queue, with its bind to the top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_checker import spq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    // Reset empties the output register on the next edge.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An overflow can only be reported with every slot in use.
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_OVERFLOW |-> m_tdata[35:32] == OCC_FULL)
        else $error("overflow with free slots");

    // An underflow reports an empty queue and the empty marker.
    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_UNDERFLOW |->
            m_tdata[35:32] == '0 && m_tdata[31:0] == HEAD_EMPTY)
        else $error("underflow with stored entries");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: dv/tb.sv
// Self-checking testbench for the sorted priority queue.
// It needs spq_pkg and sorted_priority_queue; a scoreboard class keeps a shadow copy of the queue.
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int QDEPTH = DEPTH_DEFAULT;
    localparam int RANDOM_PER_PHASE = 176;

    // Shadow queue plus the list of outcomes that the block still owes us.
    class queue_scoreboard;
        typedef struct {
            logic signed [DATA_W-1:0] value;
            logic signed [DATA_W-1:0] prio;
        } entry_t;

        typedef struct {
            logic signed [DATA_W-1:0] head_value;
            status_t                  status;
            logic [OCC_W-1:0]         occupancy;
        } outcome_t;

        entry_t   shadow_queue[$];
        outcome_t expected_outcomes[$];
        int       depth;
        int       errors;

        function new(int queue_depth);
            depth  = queue_depth;
            errors = 0;
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        // Apply one accepted request to the shadow queue and record its outcome.
        function void note_request(op_t op, logic signed [DATA_W-1:0] value,
                                   logic signed [DATA_W-1:0] prio);
            outcome_t res;
            entry_t   e;
            int       pos;
            res.head_value = '0;
            res.status     = ST_OK;
            case (op)
                OP_ENQ: begin
                    if (shadow_queue.size() >= depth) begin
                        res.status = ST_OVERFLOW;
                    end else begin
                        // Go past every entry of lower or equal priority, so ties stay FIFO.
                        pos = 0;
                        while (pos < shadow_queue.size() && shadow_queue[pos].prio <= prio)
                            pos++;
                        e.value = value;
                        e.prio  = prio;
                        shadow_queue.insert(pos, e);
                    end
                end
                OP_DEQ, OP_PEEK: begin
                    if (shadow_queue.size() == 0) begin
                        res.head_value = HEAD_EMPTY;
                        res.status     = ST_UNDERFLOW;
                    end else begin
                        res.head_value = shadow_queue[0].value;
                        if (op == OP_DEQ)
                            void'(shadow_queue.pop_front());
                    end
                end
                default: ;
            endcase
            res.occupancy = OCC_W'(shadow_queue.size());
            expected_outcomes.push_back(res);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] head_value, status_t status,
                                   logic [OCC_W-1:0] occupancy);
            outcome_t exp_res;
            if (expected_outcomes.size() == 0) begin
                $display("%0t: result beat with nothing expected (head %0d status %0d occ %0d)",
                         $time, head_value, status, occupancy);
                errors++;
                return;
            end
            exp_res = expected_outcomes.pop_front();
            if (head_value !== exp_res.head_value) begin
                $display("%0t: head_value expected %0d actual %0d",
                         $time, exp_res.head_value, head_value);
                errors++;
            end
            if (status !== exp_res.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
                errors++;
            end
            if (occupancy !== exp_res.occupancy) begin
                $display("%0t: occupancy expected %0d actual %0d",
                         $time, exp_res.occupancy, occupancy);
                errors++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = OP_NOP;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    int send_idle_pct = 8;
    int recv_idle_pct = 50;

    queue_scoreboard sb = new(QDEPTH);

    sorted_priority_queue #(.DEPTH(QDEPTH)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] item_value, [63:32] item_priority
        .s_tuser  (s_tuser),   // [1:0] op
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] head_value, [35:32] occupancy
        .m_tuser  (m_tuser)    // [1:0] status
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Receiver backpressure follows the current idling mix.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Both handshakes are sampled at the edge, before any driver update lands.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[31:0], status_t'(m_tuser), m_tdata[35:32]);
            if (s_tvalid && s_tready)
                sb.note_request(op_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]);
        end
    end

    // Present one request beat, with random idle cycles ahead of it.
    task automatic send_request(op_t op, logic [31:0] value, logic [31:0] prio);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {prio, value};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the sender off until every outstanding result has been seen. The first
    // edge lets the monitor record the beat accepted at the edge we returned on.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [31:0] random_priority();
        int pick;
        pick = $urandom_range(0, 99);
        // Half of the picks fall in a narrow band around zero, so ties and FIFO order come up often.
        if (pick < 50)
            return 32'($urandom_range(0, 7)) - 32'd4;
        else if (pick < 58)
            return 32'h7FFF_FFFF;
        else if (pick < 66)
            return 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic op_t random_op(int enq_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return OP_NOP;
        if (pick < 16)
            return OP_PEEK;
        return ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
    endfunction

    // Bursts lean toward enqueue or dequeue so the queue swings between full and empty.
    task automatic send_random_phase(int count);
        int   enq_pct;
        op_t  op;
        logic [31:0] value;
        for (int n = 0; n < count; n++) begin
            if (n % 16 == 0) begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 50;
                    default: enq_pct = 20;
                endcase
            end
            op    = random_op(enq_pct);
            value = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
            send_request(op, value, random_priority());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty queue, unused op code, fill with extreme and tied priorities,
        // overflow, then empty it again down to another underflow.
        send_request(OP_DEQ,  32'h1234_5678, 32'h0000_0001);
        send_request(OP_PEEK, 32'h0, 32'h0);
        send_request(OP_NOP,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_ENQ,  32'h0000_0001, 32'h0000_0000);
        send_request(OP_ENQ,  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(OP_ENQ,  32'h8000_0000, 32'h8000_0000);
        send_request(OP_ENQ,  32'h0000_0002, 32'h0000_0000);
        send_request(OP_ENQ,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_ENQ,  32'h0000_0003, 32'h7FFF_FFFF);
        send_request(OP_ENQ,  32'h0000_0004, 32'h8000_0000);
        send_request(OP_ENQ,  32'hA5A5_5A5A, 32'h0000_0005);
        send_request(OP_ENQ,  32'hDEAD_BEEF, 32'h8000_0000);
        send_request(OP_NOP,  32'h0, 32'h0);
        send_request(OP_PEEK, 32'h0, 32'h0);
        repeat (8) send_request(OP_DEQ, $urandom, $urandom);
        send_request(OP_DEQ,  32'h0, 32'h0);
        drain_results();

        send_idle_pct = 8;
        recv_idle_pct = 50;
        send_random_phase(RANDOM_PER_PHASE);
        drain_results();

        send_idle_pct = 50;
        recv_idle_pct = 8;
        send_random_phase(RANDOM_PER_PHASE);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_phase(RANDOM_PER_PHASE);
        drain_results();

        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: sorted_priority_queue.f
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
dv/tb.sv
